// ----- rtl/sync_frame_deadzone_scaler_macros.svh -----
// Assertion macros shared by the RTL of the sync-framed dead-zone scaler.
// Depends on nothing; included by the files that carry assertions.
`ifndef SYNC_FRAME_DEADZONE_SCALER_MACROS_SVH
`define SYNC_FRAME_DEADZONE_SCALER_MACROS_SVH

`ifndef SYNTHESIS
`define SFDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SFDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SFDS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SFDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/sfds_pkg.sv -----
// Types and constants of the sync-framed dead-zone scaler.
// Depends on nothing; used by the channel interfaces and the top level.
package sfds_pkg;

    localparam int BYTE_W  = 8;
    localparam int SLOT_W  = 5;
    localparam int DZ_W    = 7;
    localparam int SCALE_W = 7;
    localparam int DIVD_W  = 13;
    localparam int DIV_STEPS = DIVD_W;
    localparam int STEP_W  = $clog2(DIV_STEPS);

    localparam logic [BYTE_W-1:0]  SYNC_BYTE  = 8'd255;
    localparam logic [BYTE_W-1:0]  CENTRE     = 8'd127;
    localparam logic [SCALE_W-1:0] HALF_SCALE = 7'd50;
    localparam logic [SLOT_W-1:0]  LAST_SLOT  = 5'd19;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [SCALE_W-1:0] t_scaled;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } t_state;

endpackage

// ----- rtl/sfds_ifs.sv -----
// Valid/ready channel interfaces for received bytes and for scaled results.
// Depends on sfds_pkg.
interface sfds_rx_if;
    import sfds_pkg::*;

    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfds_res_if;
    import sfds_pkg::*;

    logic    valid;
    logic    ready;
    t_slot   slot;
    t_byte   raw_value;
    logic    pressed;
    t_scaled scaled;
    logic    frame_done;

    modport source (output valid, output slot, output raw_value, output pressed,
                    output scaled, output frame_done, input ready);
    modport sink (input valid, input slot, input raw_value, input pressed,
                  input scaled, input frame_done, output ready);
endinterface

// ----- rtl/sync_frame_deadzone_scaler.sv -----
// Sync-framed byte receiver that scales each payload byte to 0..100 with a dead zone.
// Depends on sfds_pkg, sfds_ifs and sync_frame_deadzone_scaler_macros.svh.
//
// A byte of 255 starts a frame when idle and aborts it inside a frame; sync bytes and
// bytes outside a frame are taken without leaving idle and give no result. A payload
// byte is taken in and its numerator formed, then goes through 13 iterations of a
// restoring divider that produces one quotient bit per cycle, and then its result is
// loaded into the output register. A result waiting in the output register does not
// hold up the acceptance of the next byte, but the load of that byte's result waits
// until the earlier result has been transferred. The dead-zone register may be written
// only while no byte is in work.
module sync_frame_deadzone_scaler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [sfds_pkg::DZ_W-1:0]     i_cfg_wr_data,
    sfds_rx_if.sink                       i_rx,
    sfds_res_if.source                    o_res
);
    import sfds_pkg::*;

`include "sync_frame_deadzone_scaler_macros.svh"

    t_state                r_state, n_state;
    logic [DZ_W-1:0]       r_deadzone;
    logic                  r_in_frame;
    t_slot                 r_slot_cnt;

    t_slot                 r_slot;
    t_byte                 r_raw;
    logic                  r_done;
    logic                  r_band;
    logic                  r_upper;
    logic                  r_zero_den;
    logic [DZ_W-1:0]       r_den;
    logic [DZ_W-1:0]       r_part;
    logic [DIVD_W-1:0]     r_quo;
    logic [STEP_W-1:0]     r_step;

    logic                  r_out_valid;
    t_slot                 r_out_slot;
    t_byte                 r_out_raw;
    logic                  r_out_pressed;
    t_scaled               r_out_scaled;
    logic                  r_out_done;

    logic                  w_acc;
    logic                  w_payload;
    logic                  w_below;
    logic [BYTE_W:0]       w_upper_edge;
    logic [DZ_W-1:0]       w_span;
    logic                  w_band;
    logic [DZ_W-1:0]       w_num;
    logic [DIVD_W-1:0]     w_dividend;
    logic [DZ_W:0]         w_trial;
    logic                  w_ge;
    logic [DZ_W:0]         w_diff;
    logic                  w_last_step;
    logic                  w_load_out;
    t_scaled               w_quot;
    t_scaled               w_scaled;

    assign w_acc     = i_rx.valid && i_rx.ready;
    assign w_payload = r_in_frame && (i_rx.rx_byte != SYNC_BYTE);

    assign w_span       = DZ_W'(CENTRE - {1'b0, r_deadzone});
    assign w_below      = i_rx.rx_byte < CENTRE;
    assign w_upper_edge = {1'b0, CENTRE} + (BYTE_W + 1)'(r_deadzone);
    assign w_band       = w_below ? (i_rx.rx_byte > {1'b0, w_span})
                                  : ({1'b0, i_rx.rx_byte} < w_upper_edge);
    assign w_num        = w_below ? DZ_W'(i_rx.rx_byte)
                                  : DZ_W'(i_rx.rx_byte - CENTRE - {1'b0, r_deadzone});
    assign w_dividend   = {1'b0, w_num, 5'b0} + {2'b0, w_num, 4'b0}
                        + {5'b0, w_num, 1'b0};

    assign w_trial     = {r_part, r_quo[DIVD_W-1]};
    assign w_ge        = w_trial >= {1'b0, r_den};
    assign w_diff      = w_trial - {1'b0, r_den};
    assign w_last_step = r_step == STEP_W'(DIV_STEPS - 1);

    assign w_quot   = r_zero_den ? '0 : r_quo[SCALE_W-1:0];
    assign w_scaled = r_band ? HALF_SCALE : (w_quot + (r_upper ? HALF_SCALE : '0));

    assign w_load_out = (r_state == ST_HOLD) && (!r_out_valid || o_res.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc && w_payload) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_last_step) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_deadzone  <= DZ_W'(6);
            r_in_frame  <= 1'b0;
            r_slot_cnt  <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_deadzone <= i_cfg_wr_data;
            end
            if (w_acc) begin
                if (!r_in_frame) begin
                    if (i_rx.rx_byte == SYNC_BYTE) begin
                        r_in_frame <= 1'b1;
                        r_slot_cnt <= '0;
                    end
                end else if (i_rx.rx_byte == SYNC_BYTE || r_slot_cnt == LAST_SLOT) begin
                    r_in_frame <= 1'b0;
                    r_slot_cnt <= '0;
                end else begin
                    r_slot_cnt <= r_slot_cnt + SLOT_W'(1);
                end
            end
            if (r_state == ST_DIV) begin
                r_step <= w_last_step ? '0 : r_step + STEP_W'(1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_payload) begin
            r_slot     <= r_slot_cnt;
            r_raw      <= i_rx.rx_byte;
            r_done     <= r_slot_cnt == LAST_SLOT;
            r_band     <= w_band;
            r_upper    <= !w_below;
            r_zero_den <= w_span == '0;
            r_den      <= w_span;
            r_part     <= '0;
            r_quo      <= w_dividend;
        end else if (r_state == ST_DIV) begin
            r_part <= w_ge ? w_diff[DZ_W-1:0] : w_trial[DZ_W-1:0];
            r_quo  <= {r_quo[DIVD_W-2:0], w_ge};
        end
        if (w_load_out) begin
            r_out_slot    <= r_slot;
            r_out_raw     <= r_raw;
            r_out_pressed <= r_raw == '0;
            r_out_scaled  <= w_scaled;
            r_out_done    <= r_done;
        end
    end

    assign i_rx.ready       = r_state == ST_IDLE;
    assign o_res.valid      = r_out_valid;
    assign o_res.slot       = r_out_slot;
    assign o_res.raw_value  = r_out_raw;
    assign o_res.pressed    = r_out_pressed;
    assign o_res.scaled     = r_out_scaled;
    assign o_res.frame_done = r_out_done;

    `SFDS_ASSERT_NEXT(a_payload_starts_div, i_clk, i_rst_n, w_acc && w_payload, r_state == ST_DIV)
    `SFDS_ASSERT_NOW(a_scaled_range, i_clk, i_rst_n, o_res.valid, o_res.scaled <= 7'd100)
    `SFDS_ASSERT_NOW(a_done_on_last, i_clk, i_rst_n, o_res.valid, o_res.frame_done == (o_res.slot == LAST_SLOT))
    `SFDS_ASSERT_NOW(a_pressed_zero, i_clk, i_rst_n, o_res.valid, o_res.pressed == (o_res.raw_value == 8'd0))

endmodule
